// File: hw/rtl/char_scanline_dot_stretch_unit_macros.svh
// Assertion macros for the character scanline dot stretch unit.
// Depends on nothing; the macros expect clk and rst_n in the using module.
`ifndef CHAR_SCANLINE_DOT_STRETCH_UNIT_MACROS_SVH
`define CHAR_SCANLINE_DOT_STRETCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CSDS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csds assertion failed");
// Next-cycle implication, checked outside reset.
`define CSDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csds assertion failed");
`else
`define CSDS_ASSERT_SAME(label, ante, cons)
`define CSDS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/csds_pkg.sv
// Shared types, constants and the scan row mapping for the dot stretch unit.
// Depends on nothing; used by the glyph RAM and the top level.
package csds_pkg;

    localparam int unsigned GLYPH_COUNT       = 128;
    localparam int unsigned ROWS_PER_GLYPH    = 16;
    localparam int unsigned CODE_W            = 7;
    localparam int unsigned ROW_W             = 4;
    localparam int unsigned GLYPH_W           = 8;
    localparam int unsigned PIX_W             = 20;
    localparam int unsigned NARROW_W          = 10;
    localparam int unsigned FILL_WIDE         = 4;
    localparam int unsigned CNT_W             = 5;
    localparam int unsigned STORE_DEPTH       = GLYPH_COUNT * ROWS_PER_GLYPH;
    localparam int unsigned ADDR_W            = $clog2(STORE_DEPTH);
    localparam int unsigned BOTTOM_ROW_OFFSET = 5;
    localparam int unsigned LAST_STORE_ROW    = ROWS_PER_GLYPH - 1;

    localparam logic [CNT_W-1:0] COUNT_NARROW = CNT_W'(NARROW_W);
    localparam logic [CNT_W-1:0] COUNT_WIDE   = CNT_W'(PIX_W);

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        DT_BOTTOM       = 2'd0,
        DT_TOP          = 2'd1,
        DT_DOUBLE_WIDTH = 2'd2,
        DT_NORMAL       = 2'd3
    } dtype_t;

    // Maps a scan row for double height, then rotates it into store order:
    // scan row 0 lives in the last store row, row r in store row r-1.
    function automatic logic [ROW_W-1:0] map_row(input logic [ROW_W-1:0] scan_row,
                                                 input dtype_t dtype);
        logic [ROW_W-1:0] r;
        r = scan_row;
        unique case (dtype)
            DT_BOTTOM:                  r = (scan_row >> 1) + ROW_W'(BOTTOM_ROW_OFFSET);
            DT_TOP:                     r = scan_row >> 1;
            DT_DOUBLE_WIDTH, DT_NORMAL: r = scan_row;
        endcase
        return (r == '0) ? ROW_W'(LAST_STORE_ROW) : (r - ROW_W'(1));
    endfunction

endpackage

// File: hw/rtl/csds_glyph_ram.sv
// Glyph store: one synchronous RAM of glyph rows with registered read data.
// Depends on csds_pkg for sizes and the scan row mapping.
module csds_glyph_ram
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [csds_pkg::CODE_W-1:0]   wr_code,
    input  logic [csds_pkg::ROW_W-1:0]    wr_row,
    input  logic [csds_pkg::GLYPH_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [csds_pkg::CODE_W-1:0]   rd_code,
    input  logic [csds_pkg::ROW_W-1:0]    rd_scan_row,
    input  csds_pkg::dtype_t              rd_dtype,
    output logic [csds_pkg::GLYPH_W-1:0]  rd_data
);
    import csds_pkg::*;

    logic [GLYPH_W-1:0] mem [STORE_DEPTH];
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [GLYPH_W-1:0] rd_data_reg;

    // Rows per glyph is sixteen, so the address is the code over the row.
    assign wr_addr = ADDR_W'({wr_code, wr_row});
    assign rd_addr = ADDR_W'({rd_code, map_row(rd_scan_row, rd_dtype)});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled consumer keeps it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/char_scanline_dot_stretch_unit.sv
// Top level of the character scanline dot stretch unit.
// Depends on csds_pkg, csds_glyph_ram and the assertion macro header.
`include "char_scanline_dot_stretch_unit_macros.svh"

// The unit takes one transaction per clock cycle on its input channel while
// input ready is high, load and render alike, and returns one result for each
// accepted render when the output side is ready. A load writes one glyph row
// into the on-chip glyph RAM in the cycle it is accepted and produces no
// result. A render reads its glyph row from that RAM's registered read port,
// then builds the stretched dots in the next stage and places them in the
// output register. Because writes and reads of the RAM happen in order at the
// accept edge, a render may directly follow the load of the row it uses. The
// carried dot is updated only when a render leaves the build stage, so
// characters of one scanline chain correctly through any stalls. The output
// register lets the unit keep accepting while a result waits; when both the
// build stage and the output register are full and output ready is low, input
// ready drops. The glyph RAM needs no clearing after reset: rows must be
// loaded before they are rendered. The user must write screen_reverse through
// the configuration port only while the unit is idle; it is not enforced.
module char_scanline_dot_stretch_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [csds_pkg::CODE_W-1:0]   char_code,
    input  logic [csds_pkg::ROW_W-1:0]    row,
    input  logic [csds_pkg::GLYPH_W-1:0]  glyph_bits,
    input  logic [1:0]                    line_mode,
    input  logic                          invert_char,
    input  logic                          line_start,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csds_pkg::PIX_W-1:0]    pixels,
    output logic [csds_pkg::CNT_W-1:0]    pixel_count
);
    import csds_pkg::*;

    op_t    in_op;
    dtype_t in_dtype;
    logic   in_accept;
    logic   code_in_range;
    logic   out_free;
    logic   build_adv;

    logic screen_reverse_reg;

    // Build stage: control of the render whose glyph row is being read.
    logic s1_valid_reg;
    logic s1_wide_reg;
    logic s1_inv_reg;
    logic s1_lstart_reg;
    logic s1_blank_reg;

    logic last_dot_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] pixels_reg;
    logic [CNT_W-1:0] count_reg;

    logic [GLYPH_W-1:0]  ram_data;
    logic [GLYPH_W-1:0]  glyph;
    logic                carry;
    logic [GLYPH_W-1:0]  stretched;
    logic [NARROW_W-1:0] narrow_dots;
    logic [PIX_W-1:0]    wide_dots;
    logic [PIX_W-1:0]    pixels_next;
    logic [CNT_W-1:0]    count_next;

    assign in_op         = op_t'(operation);
    assign in_dtype      = dtype_t'(line_mode);
    assign code_in_range = int'(char_code) < GLYPH_COUNT;

    // The build stage advances when it is empty or its result can move on.
    assign out_free  = !out_valid_reg || out_ready;
    assign build_adv = !s1_valid_reg || out_free;
    assign in_ready  = build_adv;
    assign in_accept = in_valid && in_ready;

    csds_glyph_ram u_glyph_ram
    (
        .clk         (clk),
        .wr_en       (in_accept && (in_op == OP_LOAD) && code_in_range),
        .wr_code     (char_code),
        .wr_row      (row),
        .wr_data     (glyph_bits),
        .rd_en       (in_accept && (in_op == OP_RENDER)),
        .rd_code     (char_code),
        .rd_scan_row (row),
        .rd_dtype    (in_dtype),
        .rd_data     (ram_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reverse_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            screen_reverse_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (build_adv)
        begin
            s1_valid_reg <= in_accept && (in_op == OP_RENDER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_wide_reg   <= (in_dtype == DT_DOUBLE_WIDTH);
            s1_inv_reg    <= invert_char ^ screen_reverse_reg;
            s1_lstart_reg <= line_start;
            s1_blank_reg  <= !code_in_range;
        end
    end

    // Dot stretching: each glyph dot is ORed with the dot to its left, the
    // leftmost one with the dot carried over from the previous character.
    always_comb
    begin
        glyph       = s1_blank_reg ? '0 : ram_data;
        carry       = s1_lstart_reg ? 1'b0 : last_dot_reg;
        stretched   = glyph | {carry, glyph[GLYPH_W-1:1]};
        narrow_dots = {stretched, glyph[0], glyph[0]} ^ {NARROW_W{s1_inv_reg}};
        wide_dots   = {PIX_W{glyph[0]}};
        for (int i = 0; i < GLYPH_W; i++)
        begin
            wide_dots[2*i+FILL_WIDE+1] = stretched[i];
            wide_dots[2*i+FILL_WIDE]   = glyph[i];
        end
        wide_dots = wide_dots ^ {PIX_W{s1_inv_reg}};
        if (s1_wide_reg)
        begin
            pixels_next = wide_dots;
            count_next  = COUNT_WIDE;
        end
        else
        begin
            pixels_next = {narrow_dots, {(PIX_W-NARROW_W){1'b0}}};
            count_next  = COUNT_NARROW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dot_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                last_dot_reg <= glyph[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            pixels_reg <= pixels_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixels      = pixels_reg;
    assign pixel_count = count_reg;

    // A render held in the build stage must not be dropped while output stalls.
    `CSDS_ASSERT_NEXT(a_build_holds, (s1_valid_reg && !out_free), s1_valid_reg)
    // An accepted load leaves nothing in the build stage.
    `CSDS_ASSERT_NEXT(a_load_no_result, (in_accept && (in_op == OP_LOAD)), !s1_valid_reg)
    // An accepted render always occupies the build stage next cycle.
    `CSDS_ASSERT_NEXT(a_render_enters, (in_accept && (in_op == OP_RENDER)), s1_valid_reg)
    // Narrow results leave their unused low dots clear.
    `CSDS_ASSERT_SAME(a_narrow_low_zero, (out_valid_reg && (count_reg == COUNT_NARROW)),
                      (pixels_reg[PIX_W-NARROW_W-1:0] == '0))

endmodule

// File: tb/tb_char_scanline_dot_stretch_unit.sv
// Self-checking testbench for char_scanline_dot_stretch_unit: glyph loads, renders, reverse video.
// Depends on csds_pkg and the unit's RTL; a local dot predictor checks every result in order.
`timescale 1ns / 100ps

module tb_char_scanline_dot_stretch_unit;

    import csds_pkg::*;

    // One input transaction as the stimulus side builds it.
    typedef struct
    {
        op_t                  op;
        logic [CODE_W-1:0]    code;
        logic [ROW_W-1:0]     scan;
        logic [GLYPH_W-1:0]   bits;
        dtype_t               dt;
        logic                 inv;
        logic                 lstart;
    } char_item_t;

    // One expected result transaction.
    typedef struct
    {
        logic [PIX_W-1:0]     dots;
        logic [CNT_W-1:0]     count;
    } dot_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation = OP_LOAD;
    logic [CODE_W-1:0]    char_code = '0;
    logic [ROW_W-1:0]     row = '0;
    logic [GLYPH_W-1:0]   glyph_bits = '0;
    logic [1:0]           line_mode = DT_NORMAL;
    logic                 invert_char = 1'b0;
    logic                 line_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     pixels;
    logic [CNT_W-1:0]     pixel_count;

    // Items waiting to be offered, and dot rows waiting to come out.
    char_item_t           char_items[$];
    dot_result_t          pending_dots[$];

    // Predictor state: a copy of the glyph RAM, the carried dot and the reverse setting.
    logic [GLYPH_W-1:0]   glyph_copy [GLYPH_COUNT][ROWS_PER_GLYPH];
    logic                 carry_dot = 1'b0;
    logic                 rev_setting = 1'b0;

    // Rows already scheduled for loading; renders never touch a row outside this set.
    bit                   row_loaded [GLYPH_COUNT][ROWS_PER_GLYPH];

    // Run control shared between the stimulus thread and the clocked processes.
    bit                   quiet = 1'b0;
    int                   hold_reqs = 0;
    int                   hold_served = 0;
    int                   errors = 0;
    int                   load_count = 0;
    int                   render_count = 0;
    int                   wide_count = 0;
    int                   checked_count = 0;
    int                   cfg_writes = 0;

    char_scanline_dot_stretch_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .char_code    (char_code),
        .row          (row),
        .glyph_bits   (glyph_bits),
        .line_mode    (line_mode),
        .invert_char  (invert_char),
        .line_start   (line_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixels       (pixels),
        .pixel_count  (pixel_count)
    );

    always #5 clk = ~clk;

    // Store row that a scan row reads: double height halves the scan row (the bottom half
    // is offset by five), then the store keeps glyph row 0 at the end and row r at r-1.
    function automatic logic [ROW_W-1:0] store_row(input logic [ROW_W-1:0] scan,
                                                   input dtype_t dt);
        logic [ROW_W-1:0] r;
        r = scan;
        if (dt == DT_BOTTOM)
            r = (scan >> 1) + 4'd5;
        else if (dt == DT_TOP)
            r = scan >> 1;
        return (r == '0) ? 4'd15 : (r - 4'd1);
    endfunction

    // Builds the stretched dots of one character and advances the carried dot. Each glyph
    // dot is ORed with the one before it; the fill dots repeat the last glyph dot.
    function automatic dot_result_t render_dots(input logic [CODE_W-1:0] code,
                                                input logic [ROW_W-1:0] scan,
                                                input dtype_t dt,
                                                input logic inv,
                                                input logic lstart);
        dot_result_t      res;
        logic [GLYPH_W-1:0] g;
        logic             prev;
        logic             flip;
        logic [PIX_W-1:0] acc;
        int               n;
        g = glyph_copy[code][store_row(scan, dt)];
        flip = inv ^ rev_setting;
        prev = lstart ? 1'b0 : carry_dot;
        acc = '0;
        n = 0;
        for (int b = GLYPH_W - 1; b >= 0; b--)
        begin
            acc = {acc[PIX_W-2:0], (g[b] | prev) ^ flip};
            n++;
            if (dt == DT_DOUBLE_WIDTH)
            begin
                acc = {acc[PIX_W-2:0], g[b] ^ flip};
                n++;
            end
            prev = g[b];
        end
        repeat ((dt == DT_DOUBLE_WIDTH) ? 4 : 2)
        begin
            acc = {acc[PIX_W-2:0], prev ^ flip};
            n++;
        end
        carry_dot = prev;
        res.dots = acc << (PIX_W - n);
        res.count = CNT_W'(n);
        return res;
    endfunction

    // Glyph rows are mostly random, with solid and empty rows mixed in.
    function automatic logic [GLYPH_W-1:0] pick_bits();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return GLYPH_W'($urandom);
    endfunction

    task automatic add_load(input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] r,
                            input logic [GLYPH_W-1:0] bits);
        char_item_t it;
        it.op = OP_LOAD;
        it.code = code;
        it.scan = r;
        it.bits = bits;
        it.dt = dtype_t'($urandom_range(0, 3));
        it.inv = 1'($urandom);
        it.lstart = 1'($urandom);
        row_loaded[code][r] = 1'b1;
        char_items.push_back(it);
    endtask

    // Queues a render, loading its glyph row first if nothing was ever written there.
    task automatic add_render(input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] scan,
                              input dtype_t dt, input logic inv, input logic lstart);
        char_item_t it;
        logic [ROW_W-1:0] srow;
        srow = store_row(scan, dt);
        if (!row_loaded[code][srow])
            add_load(code, srow, pick_bits());
        it.op = OP_RENDER;
        it.code = code;
        it.scan = scan;
        it.bits = GLYPH_W'($urandom);
        it.dt = dt;
        it.inv = inv;
        it.lstart = lstart;
        char_items.push_back(it);
    endtask

    // Random scanlines: one scan row and display type per line, a line start on the first
    // character most of the time, and the odd stray line start or glyph load in between.
    task automatic fill_scanlines(input int target);
        int start_len;
        int len;
        logic [ROW_W-1:0] scan;
        dtype_t dt;
        logic [CODE_W-1:0] code;
        start_len = char_items.size();
        while (char_items.size() - start_len < target)
        begin
            len = $urandom_range(1, 10);
            scan = ROW_W'($urandom_range(0, 15));
            dt = dtype_t'($urandom_range(0, 3));
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_load(CODE_W'($urandom_range(0, GLYPH_COUNT - 1)),
                             ROW_W'($urandom_range(0, 15)), pick_bits());
                if ($urandom_range(0, 1) != 0)
                    code = CODE_W'($urandom_range(0, 15));
                else
                    code = CODE_W'($urandom_range(0, GLYPH_COUNT - 1));
                add_render(code, scan, dt, 1'($urandom),
                           (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0));
            end
        end
    endtask

    // Waits until every queued item went in and every expected result came out, then
    // lets the pipeline settle after a trailing load.
    task automatic drain();
        @(negedge clk);
        while (char_items.size() != 0 || in_valid || pending_dots.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The register is only written while the unit is idle, so the predictor's copy can
    // change at the same edge.
    task automatic write_reverse(input logic value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        rev_setting = value;
        cfg_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: offers queued items, keeps valid and payload steady until the transaction is
    // accepted, and inserts random idle bursts outside the quiet phase. Every accepted
    // transaction is applied to the predictor at the edge where it is taken.
    int gap_left = 0;

    always @(posedge clk)
    begin
        char_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD)
                begin
                    glyph_copy[char_code][row] = glyph_bits;
                    load_count++;
                end
                else
                begin
                    pending_dots.push_back(render_dots(char_code, row, dtype_t'(line_mode),
                                                       invert_char, line_start));
                    render_count++;
                    if (line_mode == DT_DOUBLE_WIDTH)
                        wide_count++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 11) == 0)
                begin
                    gap_left = $urandom_range(1, 12) - 1;
                    in_valid <= 1'b0;
                end
                else if (char_items.size() != 0)
                begin
                    it = char_items.pop_front();
                    in_valid <= 1'b1;
                    operation <= it.op;
                    char_code <= it.code;
                    row <= it.scan;
                    glyph_bits <= it.bits;
                    line_mode <= it.dt;
                    invert_char <= it.inv;
                    line_start <= it.lstart;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation, field by field.
    // Ready drops in short random bursts, and for a long stretch whenever the stimulus
    // thread asks for one, so that the unit backs up and stalls its input.
    int stall_left = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        dot_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked_count++;
                if (pending_dots.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, pixels %05h count %0d",
                             $time, pixels, pixel_count);
                end
                else
                begin
                    want = pending_dots.pop_front();
                    if (pixels !== want.dots)
                    begin
                        errors++;
                        $display("%0t: pixels mismatch, expected %05h, actual %05h",
                                 $time, want.dots, pixels);
                    end
                    if (pixel_count !== want.count)
                    begin
                        errors++;
                        $display("%0t: pixel_count mismatch, expected %0d, actual %0d",
                                 $time, want.count, pixel_count);
                    end
                end
            end
            if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side means a hang.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 4000)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("tb_char_scanline_dot_stretch_unit failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with normal video: extreme codes and rows, every display type,
        // both invert values, chained and restarted lines, and a load between two
        // characters of one line, which must not disturb the carried dot.
        write_reverse(1'b0);
        add_load(7'd127, 4'd15, 8'hFF);
        add_load(7'd0, 4'd0, 8'h00);
        add_render(7'd127, 4'd0, DT_NORMAL, 1'b0, 1'b1);
        add_render(7'd0, 4'd1, DT_NORMAL, 1'b0, 1'b0);
        add_render(7'd127, 4'd0, DT_DOUBLE_WIDTH, 1'b1, 1'b1);
        add_load(7'd1, 4'd11, 8'hA5);
        add_load(7'd1, 4'd4, 8'h5A);
        add_render(7'd1, 4'd15, DT_BOTTOM, 1'b0, 1'b0);
        add_render(7'd1, 4'd0, DT_BOTTOM, 1'b1, 1'b0);
        add_render(7'd127, 4'd0, DT_TOP, 1'b0, 1'b1);
        add_render(7'd127, 4'd15, DT_TOP, 1'b0, 1'b0);
        add_render(7'd0, 4'd15, DT_NORMAL, 1'b1, 1'b0);
        add_load(7'd127, 4'd14, 8'h01);
        add_render(7'd127, 4'd15, DT_NORMAL, 1'b0, 1'b0);
        add_render(7'd127, 4'd15, DT_DOUBLE_WIDTH, 1'b0, 1'b0);
        add_render(7'd0, 4'd1, DT_DOUBLE_WIDTH, 1'b1, 1'b0);
        add_load(7'd0, 4'd0, 8'h81);
        add_render(7'd0, 4'd1, DT_NORMAL, 1'b0, 1'b0);
        add_render(7'd0, 4'd1, DT_NORMAL, 1'b0, 1'b1);
        drain();

        // Reverse video with a long output hold at the start, so the input backs up.
        write_reverse(1'b1);
        hold_reqs++;
        fill_scanlines(450);
        drain();

        // Normal video, again with a long hold.
        write_reverse(1'b0);
        hold_reqs++;
        fill_scanlines(450);
        drain();

        // Reverse video at full rate on both sides.
        write_reverse(1'b1);
        quiet = 1'b1;
        fill_scanlines(450);
        drain();

        repeat (8) @(posedge clk);
        if (pending_dots.size() != 0)
        begin
            errors += pending_dots.size();
            $display("%0t: %0d expected results never arrived", $time, pending_dots.size());
        end
        $display("Ran %0d glyph loads and %0d renders (%0d double width)",
                 load_count, render_count, wide_count);
        $display("over %0d reverse settings; %0d results compared, %0d mismatches.",
                 cfg_writes, checked_count, errors);
        if (errors == 0)
            $display("tb_char_scanline_dot_stretch_unit passed");
        else
            $display("tb_char_scanline_dot_stretch_unit failed");
        $finish;
    end

endmodule
